// ----- rtl/core/sps_pkg.sv -----
// Shared types, constants and helper functions for the spectral Poisson scaler.
`timescale 1ns / 1ps
package sps_pkg;

    localparam int MaxN       = 1024;
    localparam int SizeW      = 11;
    localparam int PosW       = 10;
    localparam int WeightW    = 48;
    localparam int HalfW      = WeightW / 2;
    localparam int FsqW       = 2 * PosW;
    localparam int ProdW      = FsqW + HalfW;
    localparam int KW         = 70;
    localparam int DataW      = 32;
    localparam int DivSteps   = 32;
    localparam int MulSteps   = 6;
    localparam int CfgIdxW    = 3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SIZE_X      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_Y      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_Z      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_START_PLANE = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_PLANE_COUNT = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_WEIGHT_X    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_WEIGHT_Y    = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_WEIGHT_Z    = 3'd7;

    localparam logic [WeightW-1:0] WeightReset = 48'd41396104;

    localparam logic signed [DataW-1:0] SatMax = 32'sh7FFF_FFFF;
    localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic signed [DataW-1:0] re;
        logic signed [DataW-1:0] im;
        logic [FsqW-1:0]         fsq_x;
        logic [FsqW-1:0]         fsq_y;
        logic [FsqW-1:0]         fsq_z;
        logic                    dc;
        logic                    last;
    } sps_item_t;

    // Grid geometry seen by the front
    typedef struct packed {
        logic [SizeW-1:0] nx;
        logic [SizeW-1:0] ny;
        logic [SizeW-1:0] nz;
        logic [SizeW-1:0] np;
        logic [PosW-1:0]  start_plane;
    } sps_geom_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } sps_state_t;

    // Clamp a size register to 1..MaxN
    function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
        logic [SizeW-1:0] r;
        begin
            r = v;
            if (v == '0)
                r = SizeW'(1);
            else if (v > SizeW'(MaxN))
                r = SizeW'(MaxN);
            return r;
        end
    endfunction

    // Squared signed frequency of index i on an axis of n points
    function automatic logic [FsqW-1:0] freq_sq(input logic [PosW-1:0] i,
                                                input logic [SizeW-1:0] n);
        logic [SizeW-1:0] iw;
        logic [SizeW-1:0] dw;
        logic [PosW-1:0]  d;
        begin
            iw = {1'b0, i};
            if (iw <= (n >> 1))
                dw = iw;
            else if (iw < n)
                dw = n - iw;
            else
                dw = iw - n;
            d = dw[PosW-1:0];
            return FsqW'(d * d);
        end
    endfunction

endpackage

// ----- rtl/core/sps_front.sv -----
// Front end: tracks the grid position and classifies each accepted item.
`timescale 1ns / 1ps
module sps_front
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sps_geom_t geom,
    input  logic      accept,
    input  logic signed [DataW-1:0] in_real,
    input  logic signed [DataW-1:0] in_imag,
    output sps_item_t item
);

    logic [PosW-1:0]  pos_plane_reg, pos_plane_next;
    logic [PosW-1:0]  pos_row_reg, pos_row_next;
    logic [PosW-1:0]  pos_col_reg, pos_col_next;
    logic [SizeW-1:0] planes_done_reg, planes_done_next;
    logic             last;
    logic [SizeW-1:0] done_inc;

    // Position step for the current item
    always_comb
    begin
        pos_plane_next   = pos_plane_reg;
        pos_row_next     = pos_row_reg;
        pos_col_next     = pos_col_reg;
        planes_done_next = planes_done_reg;
        last             = 1'b0;
        done_inc         = planes_done_reg + SizeW'(1);
        if (({1'b0, pos_col_reg} + SizeW'(1)) >= geom.nz)
        begin
            pos_col_next = '0;
            if (({1'b0, pos_row_reg} + SizeW'(1)) >= geom.ny)
            begin
                pos_row_next     = '0;
                planes_done_next = done_inc;
                if (({1'b0, pos_plane_reg} + SizeW'(1)) >= geom.nx)
                    pos_plane_next = '0;
                else
                    pos_plane_next = pos_plane_reg + PosW'(1);
                if (done_inc >= geom.np)
                begin
                    last             = 1'b1;
                    planes_done_next = '0;
                    pos_plane_next   = geom.start_plane;
                end
            end
            else
            begin
                pos_row_next = pos_row_reg + PosW'(1);
            end
        end
        else
        begin
            pos_col_next = pos_col_reg + PosW'(1);
        end
    end

    // Classified item
    always_comb
    begin
        item.re    = in_real;
        item.im    = in_imag;
        item.fsq_x = freq_sq(pos_plane_reg, geom.nx);
        item.fsq_y = freq_sq(pos_row_reg, geom.ny);
        item.fsq_z = freq_sq(pos_col_reg, geom.nz);
        item.dc    = (pos_plane_reg == '0) && (pos_row_reg == '0) && (pos_col_reg == '0);
        item.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_plane_reg   <= '0;
            pos_row_reg     <= '0;
            pos_col_reg     <= '0;
            planes_done_reg <= '0;
        end
        else if (accept)
        begin
            pos_plane_reg   <= pos_plane_next;
            pos_row_reg     <= pos_row_next;
            pos_col_reg     <= pos_col_next;
            planes_done_reg <= planes_done_next;
        end
    end

endmodule

// ----- rtl/core/sps_fifo.sv -----
// Two-entry item queue between the front and the back.
`timescale 1ns / 1ps
module sps_fifo
    import sps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sps_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output sps_item_t pop_item
);

    sps_item_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/core/sps_back.sv -----
// Back end: forms k2 on a shared multiplier and divides both parts bit by bit.
`timescale 1ns / 1ps
module sps_back
    import sps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [WeightW-1:0] weight_x,
    input  logic [WeightW-1:0] weight_y,
    input  logic [WeightW-1:0] weight_z,
    input  logic               q_not_empty,
    input  sps_item_t          q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [DataW-1:0] out_real,
    output logic signed [DataW-1:0] out_imag,
    output logic               saturated,
    output logic               slab_last
);

    sps_state_t         state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    sps_item_t          item_reg;
    logic [KW-1:0]      k_reg;
    logic [ProdW-1:0]   prod_reg;
    logic               half_reg;

    logic [KW-1:0]      rem_reg [2];
    logic [DataW-1:0]   q_reg   [2];
    logic               fix_reg [2];
    logic               sat_reg [2];
    logic               neg_reg [2];

    logic               out_valid_reg;
    logic signed [DataW-1:0] out_real_reg, out_imag_reg;
    logic               saturated_reg, slab_last_reg;

    logic               out_free;
    logic [FsqW-1:0]    fsq_sel;
    logic [WeightW-1:0] w_sel;
    logic [HalfW-1:0]   w_half;
    logic [DataW-1:0]   res    [2];
    logic               res_sat[2];

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_MUL;
                    cnt_next   = '0;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == 6'(MulSteps))
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 6'(DivSteps))
                    state_next = S_DONE;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Multiplier operand select: axis from the step, low half then high half
    always_comb
    begin
        case (cnt_reg[2:1])
            2'd0:    begin fsq_sel = item_reg.fsq_x; w_sel = weight_x; end
            2'd1:    begin fsq_sel = item_reg.fsq_y; w_sel = weight_y; end
            default: begin fsq_sel = item_reg.fsq_z; w_sel = weight_z; end
        endcase
        w_half = cnt_reg[0] ? w_sel[WeightW-1:HalfW] : w_sel[HalfW-1:0];
    end

    // Final saturation and sign restore per part
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [DataW-1:0] limit;
            logic [DataW-1:0] qv;
            logic             s;
            limit = neg_reg[l] ? DataW'(SatMin) : DataW'(SatMax);
            qv    = q_reg[l];
            s     = sat_reg[l];
            if (!fix_reg[l] && (qv > limit))
            begin
                s  = 1'b1;
                qv = limit;
            end
            if (fix_reg[l])
                qv = sat_reg[l] ? limit : '0;
            res[l]     = neg_reg[l] ? (~qv + DataW'(1)) : qv;
            res_sat[l] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            k_reg    <= '0;
        end
        if (state_reg == S_MUL)
        begin
            if (cnt_reg < 6'(MulSteps))
            begin
                prod_reg <= ProdW'(fsq_sel * w_half);
                half_reg <= cnt_reg[0];
            end
            if (cnt_reg != '0)
                k_reg <= k_reg + (half_reg ? (KW'(prod_reg) << HalfW) : KW'(prod_reg));
        end
        if (state_reg == S_DIV)
        begin
            for (int l = 0; l < 2; l++)
            begin
                logic [DataW-1:0] raw;
                logic [DataW-1:0] mag;
                logic [KW:0]      r2;
                raw = (l == 0) ? item_reg.re : item_reg.im;
                mag = raw[DataW-1] ? (~raw + DataW'(1)) : raw;
                r2  = {rem_reg[l], 1'b0};
                if (cnt_reg == '0)
                begin
                    // Zero, DC and overflow cases settle before the iterations
                    neg_reg[l] <= raw[DataW-1];
                    q_reg[l]   <= '0;
                    rem_reg[l] <= KW'({mag, 8'b0});
                    if (item_reg.dc || mag == '0)
                    begin
                        fix_reg[l] <= 1'b1;
                        sat_reg[l] <= 1'b0;
                    end
                    else if (KW'({mag, 8'b0}) >= k_reg)
                    begin
                        fix_reg[l] <= 1'b1;
                        sat_reg[l] <= 1'b1;
                    end
                    else
                    begin
                        fix_reg[l] <= 1'b0;
                        sat_reg[l] <= 1'b0;
                    end
                end
                else if (r2 >= {1'b0, k_reg})
                begin
                    rem_reg[l] <= KW'(r2 - {1'b0, k_reg});
                    q_reg[l]   <= {q_reg[l][DataW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[l] <= r2[KW-1:0];
                    q_reg[l]   <= {q_reg[l][DataW-2:0], 1'b0};
                end
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_real_reg  <= res[0];
            out_imag_reg  <= res[1];
            saturated_reg <= res_sat[0] || res_sat[1];
            slab_last_reg <= item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_real  = out_real_reg;
    assign out_imag  = out_imag_reg;
    assign saturated = saturated_reg;
    assign slab_last = slab_last_reg;

    // The queue is drained only by an idle back end
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE && q_not_empty))
        else $error("pop outside idle");

    // Step counter stays within the multiply sequence
    a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg <= 6'(MulSteps)))
        else $error("multiply step out of range");

    // Step counter stays within the division sequence
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= 6'(DivSteps)))
        else $error("divide step out of range");

    // A clipped result sits at a range extreme in at least one part
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && saturated_reg) |->
            (out_real_reg == SatMax || out_real_reg == SatMin ||
             out_imag_reg == SatMax || out_imag_reg == SatMin))
        else $error("saturated flag without clipped value");

endmodule

// ----- rtl/core/spectral_poisson_scaler.sv -----
// Top level: configuration registers, front end, item queue and back end.
`timescale 1ns / 1ps
// Divides streamed 3D spectral samples (raster order, z fastest) by the squared
// wavenumber k2 and saturates to Q16.16; the DC bin gives zero and the last
// element of the slab is marked. In the back end, six passes through one
// shared 20x24 multiplier build k2, then a restoring divider produces one
// quotient bit per cycle for both parts in parallel. A two-entry queue lets
// up to two items wait ahead of the back end, and the output register holds
// a finished result while the next is computed. The user must write
// configuration only while no item is in flight; the block does not enforce it.
module spectral_poisson_scaler
    import sps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [WeightW-1:0]       cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DataW-1:0]  in_real,
    input  logic signed [DataW-1:0]  in_imag,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DataW-1:0]  out_real,
    output logic signed [DataW-1:0]  out_imag,
    output logic                     saturated,
    output logic                     slab_last
);

    logic [SizeW-1:0]   size_x_reg, size_y_reg, size_z_reg, plane_count_reg;
    logic [PosW-1:0]    start_plane_reg;
    logic [WeightW-1:0] weight_x_reg, weight_y_reg, weight_z_reg;

    sps_geom_t geom;
    sps_item_t front_item, q_item;
    logic      accept, q_full, q_not_empty, q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg      <= SizeW'(MaxN);
            size_y_reg      <= SizeW'(MaxN);
            size_z_reg      <= SizeW'(MaxN);
            start_plane_reg <= '0;
            plane_count_reg <= SizeW'(MaxN);
            weight_x_reg    <= WeightReset;
            weight_y_reg    <= WeightReset;
            weight_z_reg    <= WeightReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X:      size_x_reg      <= cfg_data[SizeW-1:0];
                CFG_SIZE_Y:      size_y_reg      <= cfg_data[SizeW-1:0];
                CFG_SIZE_Z:      size_z_reg      <= cfg_data[SizeW-1:0];
                CFG_START_PLANE: start_plane_reg <= cfg_data[PosW-1:0];
                CFG_PLANE_COUNT: plane_count_reg <= cfg_data[SizeW-1:0];
                CFG_WEIGHT_X:    weight_x_reg    <= cfg_data;
                CFG_WEIGHT_Y:    weight_y_reg    <= cfg_data;
                CFG_WEIGHT_Z:    weight_z_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        geom.nx          = clamp_size(size_x_reg);
        geom.ny          = clamp_size(size_y_reg);
        geom.nz          = clamp_size(size_z_reg);
        geom.np          = clamp_size(plane_count_reg);
        geom.start_plane = start_plane_reg;
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    sps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .accept  (accept),
        .in_real (in_real),
        .in_imag (in_imag),
        .item    (front_item)
    );

    sps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    sps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .weight_x    (weight_x_reg),
        .weight_y    (weight_y_reg),
        .weight_z    (weight_z_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_real    (out_real),
        .out_imag    (out_imag),
        .saturated   (saturated),
        .slab_last   (slab_last)
    );

endmodule

// ----- verif/spectral_poisson_scaler_tb.sv -----
// Self-checking testbench for the spectral Poisson scaler.
`timescale 1ns / 1ps
module spectral_poisson_scaler_tb;
    import sps_pkg::*;

    typedef struct {
        logic [DataW-1:0] re;
        logic [DataW-1:0] im;
        bit               sat;
        bit               last;
    } scaled_t;

    typedef struct {
        logic [DataW-1:0] re;
        logic [DataW-1:0] im;
    } sample_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CfgIdxW-1:0]      cfg_index;
    logic [WeightW-1:0]      cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [DataW-1:0] in_real;
    logic signed [DataW-1:0] in_imag;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [DataW-1:0] out_real;
    logic signed [DataW-1:0] out_imag;
    logic                    saturated;
    logic                    slab_last;

    spectral_poisson_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_real   (in_real),
        .in_imag   (in_imag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_real  (out_real),
        .out_imag  (out_imag),
        .saturated (saturated),
        .slab_last (slab_last)
    );

    // Predictor copy of registers and grid position
    int unsigned      grid_x, grid_y, grid_z, first_plane, slab_planes;
    logic [WeightW-1:0] wt_x, wt_y, wt_z;
    int unsigned      at_plane, at_row, at_col, planes_seen;

    sample_t pending_samples[$];
    scaled_t expected_scaled[$];
    int      errors;
    int      sender_idle_pct;
    int      recv_stall_pct;
    int      hold_left;
    int      quiet_cycles;
    bit      taken;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                   input logic [DataW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int unsigned clamp_dim(input int unsigned v);
        if (v < 1) return 1;
        if (v > MaxN) return MaxN;
        return v;
    endfunction

    // Squared signed frequency of grid index i on an axis of n points
    function automatic logic [63:0] wave_sq(input int unsigned i, input int unsigned n);
        logic [63:0] d;
        if (i <= n / 2) d = 64'(i);
        else if (i < n) d = 64'(n - i);
        else d = 64'(i - n);
        return d * d;
    endfunction

    // One part divided by k (Q8.40), truncated and clipped to Q16.16
    function automatic logic [DataW-1:0] scale_part(input logic [DataW-1:0] raw,
                                                    input logic [127:0] k,
                                                    output bit clip);
        bit           neg;
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] limit;
        clip = 0;
        neg = raw[31];
        mag = neg ? (128'h1_0000_0000 - 128'(raw)) : 128'(raw);
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag == 0) return '0;
        if (k == 0)
        begin
            clip = 1;
            return limit[31:0];
        end
        q = (mag << 40) / k;
        if (q > limit)
        begin
            clip = 1;
            q = limit;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // Work out the result of one accepted sample and advance the position
    function automatic void predict_scaled(input logic [DataW-1:0] re,
                                           input logic [DataW-1:0] im);
        int unsigned  nx, ny, nz, np;
        logic [127:0] k;
        bit           c0, c1;
        scaled_t      r;
        nx = clamp_dim(grid_x);
        ny = clamp_dim(grid_y);
        nz = clamp_dim(grid_z);
        np = clamp_dim(slab_planes);
        r = '{re: '0, im: '0, sat: 0, last: 0};
        if (!(at_plane == 0 && at_row == 0 && at_col == 0))
        begin
            k = 128'(wave_sq(at_plane, nx)) * 128'(wt_x)
                + 128'(wave_sq(at_row, ny)) * 128'(wt_y)
                + 128'(wave_sq(at_col, nz)) * 128'(wt_z);
            r.re = scale_part(re, k, c0);
            r.im = scale_part(im, k, c1);
            r.sat = c0 | c1;
        end
        if (at_col + 1 >= nz)
        begin
            at_col = 0;
            if (at_row + 1 >= ny)
            begin
                at_row = 0;
                planes_seen++;
                at_plane = (at_plane + 1 >= nx) ? 0 : at_plane + 1;
                if (planes_seen >= np)
                begin
                    r.last = 1;
                    planes_seen = 0;
                    at_plane = first_plane;
                end
            end
            else
                at_row++;
        end
        else
            at_col++;
        expected_scaled.push_back(r);
    endfunction

    // Input acceptance, result check and stall watchdog
    always @(posedge clk)
    begin
        scaled_t e;
        if (rst_n)
        begin
            quiet_cycles++;
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (expected_scaled.size() == 0)
                begin
                    report_mismatch("unexpected result", out_real, '0);
                end
                else
                begin
                    e = expected_scaled.pop_front();
                    if (out_real !== e.re) report_mismatch("out_real", out_real, e.re);
                    if (out_imag !== e.im) report_mismatch("out_imag", out_imag, e.im);
                    if (saturated !== e.sat)
                        report_mismatch("saturated", DataW'(saturated), DataW'(e.sat));
                    if (slab_last !== e.last)
                        report_mismatch("slab_last", DataW'(slab_last), DataW'(e.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                taken = 1;
                predict_scaled(in_real, in_imag);
            end
            if (quiet_cycles >= 20000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Sample driver
    always @(negedge clk)
    begin
        sample_t s;
        if (rst_n && (!in_valid || taken))
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                s = pending_samples.pop_front();
                in_valid <= 1'b1;
                in_real <= s.re;
                in_imag <= s.im;
            end
            else
                in_valid <= 1'b0;
        end
        taken = 0;
    end

    // Result receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WeightW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SIZE_X:      grid_x = 32'(val[10:0]);
            CFG_SIZE_Y:      grid_y = 32'(val[10:0]);
            CFG_SIZE_Z:      grid_z = 32'(val[10:0]);
            CFG_START_PLANE: first_plane = 32'(val[9:0]);
            CFG_PLANE_COUNT: slab_planes = 32'(val[10:0]);
            CFG_WEIGHT_X:    wt_x = val;
            CFG_WEIGHT_Y:    wt_y = val;
            CFG_WEIGHT_Z:    wt_z = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int unsigned sx, sy, sz, sp, pc,
                            input logic [WeightW-1:0] wx, wy, wz);
        write_reg(CFG_SIZE_X, WeightW'(sx));
        write_reg(CFG_SIZE_Y, WeightW'(sy));
        write_reg(CFG_SIZE_Z, WeightW'(sz));
        write_reg(CFG_START_PLANE, WeightW'(sp));
        write_reg(CFG_PLANE_COUNT, WeightW'(pc));
        write_reg(CFG_WEIGHT_X, wx);
        write_reg(CFG_WEIGHT_Y, wy);
        write_reg(CFG_WEIGHT_Z, wz);
    endtask

    // Block until every queued sample has produced its result, then settle
    task automatic drain_all();
        while (pending_samples.size() != 0 || in_valid || expected_scaled.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [DataW-1:0] rand_part();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom_range(255);
            4: return -$urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WeightW-1:0] rand_weight();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            default: return w[47:0] >> $urandom_range(47);
        endcase
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_samples.push_back('{re: rand_part(), im: rand_part()});
    endtask

    initial
    begin
        logic [DataW-1:0] corner[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_real = '0;
        in_imag = '0;
        out_stall = 1'b0;
        errors = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        taken = 0;
        grid_x = 1024; grid_y = 1024; grid_z = 1024;
        first_plane = 0; slab_planes = 1024;
        wt_x = WeightReset; wt_y = WeightReset; wt_z = WeightReset;
        at_plane = 0; at_row = 0; at_col = 0; planes_seen = 0;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        // Directed: field extremes over a small grid, DC bin first
        set_grid(3, 2, 2, 0, 2, WeightReset, WeightReset, 48'h100_0000_0000);
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
        for (int i = 0; i < 12; i++)
            pending_samples.push_back('{re: corner[i % 6], im: corner[(i + 3) % 6]});
        drain_all();

        // Zero k2 away from DC: nonzero parts clip, zero parts do not
        set_grid(2, 2, 3, 0, 1, '0, '0, '0);
        for (int i = 0; i < 12; i++)
            pending_samples.push_back('{re: corner[i % 6], im: (i % 2) ? 32'h0 : corner[5 - i % 6]});
        drain_all();

        // Clamped sizes and a slab starting past the grid end
        set_grid(0, 1, 2047, 1023, 0, '1, '1, 48'h1);
        queue_random(10);
        drain_all();
        set_grid(1024, 1024, 1024, 1023, 1024, 48'h1, 48'h1, 48'h1);
        queue_random(8);
        drain_all();

        // Random grids, cycling the idling modes
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            set_grid($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 6),
                     ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(5),
                     $urandom_range(0, 4), rand_weight(), rand_weight(), rand_weight());
            // Long output hold-off while the sender keeps offering
            if (ph == 2)
                hold_left = 400;
            queue_random(35);
            // Sender pauses until all results are back
            drain_all();
            queue_random(35);
            drain_all();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
